// ===== sv/oas_pkg.sv =====
// shared widths and payload types for the box overlap separating axis pipeline
// no dependencies; imported by oas_axis_test, obb_aabb_overlap_sat_2d_unit and the testbench
`default_nettype none

package oas_pkg;

  // field formats
  localparam int COORD_WIDTH = 32;
  localparam int AXIS_WIDTH  = 16;
  localparam int AXIS_FRAC   = AXIS_WIDTH - 2;
  localparam int HALF_WIDTH  = COORD_WIDTH - 1;

  // doubled aligned box centre offset and extent
  localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
  localparam int EXT_WIDTH   = COORD_WIDTH + 1;

  // axis dot products and their magnitudes
  localparam int DOT_WIDTH   = 2 * AXIS_WIDTH + 1;
  localparam int DMAG_WIDTH  = 2 * AXIS_WIDTH;

  // projected centre distance and aligned box radius on an oriented axis
  localparam int PROJ_WIDTH  = DIFF_WIDTH + AXIS_WIDTH + 1;

  // oriented box radius terms
  localparam int RAD_WIDTH   = HALF_WIDTH + DMAG_WIDTH + 1;
  localparam int WRAD_WIDTH  = HALF_WIDTH + AXIS_WIDTH + 1;

  // final comparison widths, oriented axes and world axes
  localparam int CMP_WIDTH   = PROJ_WIDTH + AXIS_FRAC + 3;
  localparam int WCMP_WIDTH  = DIFF_WIDTH + AXIS_FRAC + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic        [AXIS_WIDTH-1:0]  amag_t;
  typedef logic        [HALF_WIDTH-1:0]  half_t;
  typedef logic signed [PROJ_WIDTH-1:0]  proj_t;
  typedef logic        [PROJ_WIDTH-1:0]  smag_t;
  typedef logic        [DMAG_WIDTH-1:0]  dmag_t;

endpackage

`default_nettype wire

// ===== sv/oas_axis_test.sv =====
// last two pipeline stages of the separation test on one oriented box axis
// depends on oas_pkg for widths and payload types
`default_nettype none

module oas_axis_test (
  input  logic           clk,
  input  oas_pkg::smag_t s_mag,
  input  oas_pkg::proj_t t_rad,
  input  oas_pkg::dmag_t d_first_mag,
  input  oas_pkg::dmag_t d_second_mag,
  input  oas_pkg::half_t half_first,
  input  oas_pkg::half_t half_second,
  output logic           sep
);
  import oas_pkg::*;

  logic [RAD_WIDTH-1:0]         o_nxt;
  logic [RAD_WIDTH-1:0]         o_r;
  smag_t                        s_mag_r;
  proj_t                        t_r;
  logic signed [CMP_WIDTH-1:0]  lhs;
  logic signed [CMP_WIDTH-1:0]  rhs;
  logic                         sep_nxt;
  logic                         sep_r;

  // oriented box radius on this axis, both half extents
  always_comb begin
    o_nxt = RAD_WIDTH'(half_first) * RAD_WIDTH'(d_first_mag)
          + RAD_WIDTH'(half_second) * RAD_WIDTH'(d_second_mag);
  end

  // scaled distance against aligned radius plus doubled oriented radius
  always_comb begin
    lhs     = CMP_WIDTH'($signed({1'b0, s_mag_r})) <<< AXIS_FRAC;
    rhs     = (CMP_WIDTH'(t_r) <<< AXIS_FRAC) + CMP_WIDTH'($signed({1'b0, o_r, 1'b0}));
    sep_nxt = lhs > rhs;
  end

  // payload stages, validity travels in the parent
  always_ff @(posedge clk) begin
    o_r     <= o_nxt;
    s_mag_r <= s_mag;
    t_r     <= t_rad;
    sep_r   <= sep_nxt;
  end

  assign sep = sep_r;

endmodule

`default_nettype wire

// ===== sv/obb_aabb_overlap_sat_2d_unit.sv =====
// oriented box against aligned box overlap, separating axis test, five stage pipeline
// depends on oas_pkg and oas_axis_test
//
//  channel  | ports                                  | transfer when
//  ---------+----------------------------------------+----------------------------
//  command  | start, busy, in_* (twelve box fields)  | start high and busy low
//  result   | out_strobe, out_overlap                | out_strobe high (no hold-off)
//
// one item per cycle sustained while busy is low; each result reaches the ports through
// one register stage per step, in order: input, products, magnitudes and world axes,
// oriented radius, final compare
// rst_n is synchronous; busy is high during reset and the first cycle after it
// the result side never stalls, so the pipeline advances every cycle
`default_nettype none

module obb_aabb_overlap_sat_2d_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  oas_pkg::coord_t in_obb_center_x,
  input  oas_pkg::coord_t in_obb_center_y,
  input  oas_pkg::axis_t  in_first_axis_x,
  input  oas_pkg::axis_t  in_first_axis_y,
  input  oas_pkg::axis_t  in_second_axis_x,
  input  oas_pkg::axis_t  in_second_axis_y,
  input  oas_pkg::half_t  in_obb_half_first,
  input  oas_pkg::half_t  in_obb_half_second,
  input  oas_pkg::coord_t in_box_min_x,
  input  oas_pkg::coord_t in_box_min_y,
  input  oas_pkg::coord_t in_box_max_x,
  input  oas_pkg::coord_t in_box_max_y,
  output logic            out_strobe,
  output logic            out_overlap
);
  import oas_pkg::*;

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic        [DIFF_WIDTH-1:0] dmagw_t;
  typedef logic signed [EXT_WIDTH-1:0]  ext_t;
  typedef logic signed [DOT_WIDTH-1:0]  dot_t;
  typedef logic        [WRAD_WIDTH-1:0] wrad_t;
  typedef logic signed [WCMP_WIDTH-1:0] wcmp_t;

  // control
  logic  busy_r;
  logic  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic  v1_nxt;

  // stage 1
  diff_t cx_e, cy_e, mnx_e, mny_e, mxx_e, mxy_e;
  diff_t dx_nxt, dy_nxt, dx_r, dy_r;
  ext_t  ex_nxt, ey_nxt, ex_r, ey_r;
  axis_t a1x_r, a1y_r, a2x_r, a2y_r;
  amag_t m1x_nxt, m1y_nxt, m2x_nxt, m2y_nxt;
  amag_t m1x_r, m1y_r, m2x_r, m2y_r;
  half_t hf1_r, hs1_r;

  // stage 2
  dot_t   p11_nxt, p12_nxt, p22_nxt, p11_r, p12_r, p22_r;
  proj_t  s1_nxt, s2_nxt, s1_r, s2_r;
  proj_t  t1_nxt, t2_nxt, t1_r, t2_r;
  wrad_t  wx_nxt, wy_nxt, wx_r, wy_r;
  dmagw_t dxm_nxt, dym_nxt, dxm_r, dym_r;
  ext_t   ex2_r, ey2_r;
  half_t  hf2_r, hs2_r;

  // stage 3
  wcmp_t  wx_lhs, wx_rhs, wy_lhs, wy_rhs;
  logic   sepw3_nxt, sepw3_r, sepw4_r, sepw5_r;
  dmag_t  p11m_nxt, p12m_nxt, p22m_nxt, p11m_r, p12m_r, p22m_r;
  smag_t  s1m_nxt, s2m_nxt, s1m_r, s2m_r;
  proj_t  t1_s3_r, t2_s3_r;
  half_t  hf3_r, hs3_r;

  // oriented axis verdicts
  logic   sep_first, sep_second;

  // busy only across reset, the pipeline never holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      v1_r   <= v1_nxt;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
    end
  end

  assign v1_nxt = start & ~busy_r;
  assign busy   = busy_r;

  // stage 1: doubled centre offset and extent of the aligned box, axis magnitudes
  always_comb begin
    cx_e    = DIFF_WIDTH'(in_obb_center_x);
    cy_e    = DIFF_WIDTH'(in_obb_center_y);
    mnx_e   = DIFF_WIDTH'(in_box_min_x);
    mny_e   = DIFF_WIDTH'(in_box_min_y);
    mxx_e   = DIFF_WIDTH'(in_box_max_x);
    mxy_e   = DIFF_WIDTH'(in_box_max_y);
    dx_nxt  = (cx_e <<< 1) - mnx_e - mxx_e;
    dy_nxt  = (cy_e <<< 1) - mny_e - mxy_e;
    ex_nxt  = EXT_WIDTH'(in_box_max_x) - EXT_WIDTH'(in_box_min_x);
    ey_nxt  = EXT_WIDTH'(in_box_max_y) - EXT_WIDTH'(in_box_min_y);
    m1x_nxt = in_first_axis_x[AXIS_WIDTH-1]  ? amag_t'(-in_first_axis_x)  : amag_t'(in_first_axis_x);
    m1y_nxt = in_first_axis_y[AXIS_WIDTH-1]  ? amag_t'(-in_first_axis_y)  : amag_t'(in_first_axis_y);
    m2x_nxt = in_second_axis_x[AXIS_WIDTH-1] ? amag_t'(-in_second_axis_x) : amag_t'(in_second_axis_x);
    m2y_nxt = in_second_axis_y[AXIS_WIDTH-1] ? amag_t'(-in_second_axis_y) : amag_t'(in_second_axis_y);
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    ex_r  <= ex_nxt;
    ey_r  <= ey_nxt;
    a1x_r <= in_first_axis_x;
    a1y_r <= in_first_axis_y;
    a2x_r <= in_second_axis_x;
    a2y_r <= in_second_axis_y;
    m1x_r <= m1x_nxt;
    m1y_r <= m1y_nxt;
    m2x_r <= m2x_nxt;
    m2y_r <= m2y_nxt;
    hf1_r <= in_obb_half_first;
    hs1_r <= in_obb_half_second;
  end

  // stage 2: axis dot products, projections and world axis radii
  always_comb begin
    p11_nxt = DOT_WIDTH'(a1x_r) * DOT_WIDTH'(a1x_r) + DOT_WIDTH'(a1y_r) * DOT_WIDTH'(a1y_r);
    p12_nxt = DOT_WIDTH'(a1x_r) * DOT_WIDTH'(a2x_r) + DOT_WIDTH'(a1y_r) * DOT_WIDTH'(a2y_r);
    p22_nxt = DOT_WIDTH'(a2x_r) * DOT_WIDTH'(a2x_r) + DOT_WIDTH'(a2y_r) * DOT_WIDTH'(a2y_r);
    s1_nxt  = PROJ_WIDTH'(dx_r) * PROJ_WIDTH'(a1x_r) + PROJ_WIDTH'(dy_r) * PROJ_WIDTH'(a1y_r);
    s2_nxt  = PROJ_WIDTH'(dx_r) * PROJ_WIDTH'(a2x_r) + PROJ_WIDTH'(dy_r) * PROJ_WIDTH'(a2y_r);
    t1_nxt  = PROJ_WIDTH'(ex_r) * PROJ_WIDTH'($signed({1'b0, m1x_r}))
            + PROJ_WIDTH'(ey_r) * PROJ_WIDTH'($signed({1'b0, m1y_r}));
    t2_nxt  = PROJ_WIDTH'(ex_r) * PROJ_WIDTH'($signed({1'b0, m2x_r}))
            + PROJ_WIDTH'(ey_r) * PROJ_WIDTH'($signed({1'b0, m2y_r}));
    wx_nxt  = WRAD_WIDTH'(hf1_r) * WRAD_WIDTH'(m1x_r) + WRAD_WIDTH'(hs1_r) * WRAD_WIDTH'(m2x_r);
    wy_nxt  = WRAD_WIDTH'(hf1_r) * WRAD_WIDTH'(m1y_r) + WRAD_WIDTH'(hs1_r) * WRAD_WIDTH'(m2y_r);
    dxm_nxt = dx_r[DIFF_WIDTH-1] ? dmagw_t'(-dx_r) : dmagw_t'(dx_r);
    dym_nxt = dy_r[DIFF_WIDTH-1] ? dmagw_t'(-dy_r) : dmagw_t'(dy_r);
  end

  always_ff @(posedge clk) begin
    p11_r <= p11_nxt;
    p12_r <= p12_nxt;
    p22_r <= p22_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    t1_r  <= t1_nxt;
    t2_r  <= t2_nxt;
    wx_r  <= wx_nxt;
    wy_r  <= wy_nxt;
    dxm_r <= dxm_nxt;
    dym_r <= dym_nxt;
    ex2_r <= ex_r;
    ey2_r <= ey_r;
    hf2_r <= hf1_r;
    hs2_r <= hs1_r;
  end

  // stage 3: world axis tests, common scale 2^frac removed from both sides
  always_comb begin
    wx_lhs    = WCMP_WIDTH'($signed({1'b0, dxm_r})) <<< AXIS_FRAC;
    wx_rhs    = (WCMP_WIDTH'(ex2_r) <<< AXIS_FRAC) + WCMP_WIDTH'($signed({1'b0, wx_r, 1'b0}));
    wy_lhs    = WCMP_WIDTH'($signed({1'b0, dym_r})) <<< AXIS_FRAC;
    wy_rhs    = (WCMP_WIDTH'(ey2_r) <<< AXIS_FRAC) + WCMP_WIDTH'($signed({1'b0, wy_r, 1'b0}));
    sepw3_nxt = (wx_lhs > wx_rhs) | (wy_lhs > wy_rhs);
  end

  // stage 3: magnitudes for the oriented axes
  always_comb begin
    p11m_nxt = p11_r[DOT_WIDTH-1] ? dmag_t'(-p11_r) : dmag_t'(p11_r);
    p12m_nxt = p12_r[DOT_WIDTH-1] ? dmag_t'(-p12_r) : dmag_t'(p12_r);
    p22m_nxt = p22_r[DOT_WIDTH-1] ? dmag_t'(-p22_r) : dmag_t'(p22_r);
    s1m_nxt  = s1_r[PROJ_WIDTH-1] ? smag_t'(-s1_r) : smag_t'(s1_r);
    s2m_nxt  = s2_r[PROJ_WIDTH-1] ? smag_t'(-s2_r) : smag_t'(s2_r);
  end

  always_ff @(posedge clk) begin
    sepw3_r <= sepw3_nxt;
    sepw4_r <= sepw3_r;
    sepw5_r <= sepw4_r;
    p11m_r  <= p11m_nxt;
    p12m_r  <= p12m_nxt;
    p22m_r  <= p22m_nxt;
    s1m_r   <= s1m_nxt;
    s2m_r   <= s2m_nxt;
    t1_s3_r <= t1_r;
    t2_s3_r <= t2_r;
    hf3_r   <= hf2_r;
    hs3_r   <= hs2_r;
  end

  // stages 4 and 5: oriented box first axis
  oas_axis_test u_first (
    .clk          (clk),
    .s_mag        (s1m_r),
    .t_rad        (t1_s3_r),
    .d_first_mag  (p11m_r),
    .d_second_mag (p12m_r),
    .half_first   (hf3_r),
    .half_second  (hs3_r),
    .sep          (sep_first)
  );

  // stages 4 and 5: oriented box second axis
  oas_axis_test u_second (
    .clk          (clk),
    .s_mag        (s2m_r),
    .t_rad        (t2_s3_r),
    .d_first_mag  (p12m_r),
    .d_second_mag (p22m_r),
    .half_first   (hf3_r),
    .half_second  (hs3_r),
    .sep          (sep_second)
  );

  // result: overlap unless some axis separates
  assign out_strobe  = v5_r;
  assign out_overlap = ~(sepw5_r | sep_first | sep_second);

  // checks
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_strobe)
    else $error("result missing five cycles after command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 5))
    else $error("result strobe without matching command transfer");

endmodule

`default_nettype wire

// ===== tb/tb_obb_aabb_overlap_sat_2d_unit.sv =====
// self-checking testbench for the oriented box against aligned box overlap unit
// depends on oas_pkg and obb_aabb_overlap_sat_2d_unit; a directed table, then random pairs,
// each result checked against its table verdict or an exact wide-integer separating axis predictor
`timescale 1ns / 100ps

module tb_obb_aabb_overlap_sat_2d_unit;

  import oas_pkg::*;

  // exact arithmetic width, far above any intermediate of the test
  typedef logic signed [127:0] exact_t;

  typedef struct packed {
    coord_t obb_center_x;
    coord_t obb_center_y;
    axis_t  first_axis_x;
    axis_t  first_axis_y;
    axis_t  second_axis_x;
    axis_t  second_axis_y;
    half_t  obb_half_first;
    half_t  obb_half_second;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_max_x;
    coord_t box_max_y;
  } box_pair_t;

  // how the expected result of a pair is obtained
  typedef enum logic [1:0] {
    WANT_APART     = 2'd0,
    WANT_OVERLAP   = 2'd1,
    WANT_PREDICTED = 2'd2
  } want_t;

  typedef struct packed {
    box_pair_t pair;
    want_t     want;
  } stim_row_t;

  localparam longint COORD_ONE = 64'sd65536;
  localparam longint AXIS_ONE  = longint'(1) << AXIS_FRAC;
  localparam longint CMAX      = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint CMIN      = -(longint'(1) << (COORD_WIDTH - 1));
  localparam longint AMAX      = (longint'(1) << (AXIS_WIDTH - 1)) - 1;
  localparam longint AMIN      = -(longint'(1) << (AXIS_WIDTH - 1));
  localparam longint HMAX      = (longint'(1) << HALF_WIDTH) - 1;
  localparam longint DIAG      = 64'sd11585;

  localparam int DIRECTED_ROWS  = 18;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  logic      out_strobe;
  logic      out_overlap;
  box_pair_t cmd = '0;
  want_t     cmd_want = WANT_PREDICTED;

  bit overlap_due[$];
  bit due;
  int failures = 0;
  int pairs_sent = 0;
  int seen_overlap = 0;
  int seen_apart = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  obb_aabb_overlap_sat_2d_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_obb_center_x    (cmd.obb_center_x),
    .in_obb_center_y    (cmd.obb_center_y),
    .in_first_axis_x    (cmd.first_axis_x),
    .in_first_axis_y    (cmd.first_axis_y),
    .in_second_axis_x   (cmd.second_axis_x),
    .in_second_axis_y   (cmd.second_axis_y),
    .in_obb_half_first  (cmd.obb_half_first),
    .in_obb_half_second (cmd.obb_half_second),
    .in_box_min_x       (cmd.box_min_x),
    .in_box_min_y       (cmd.box_min_y),
    .in_box_max_x       (cmd.box_max_x),
    .in_box_max_y       (cmd.box_max_y),
    .out_strobe         (out_strobe),
    .out_overlap        (out_overlap)
  );

  function automatic exact_t magnitude(exact_t v);
    return (v < 0) ? -v : v;
  endfunction

  // one candidate axis: centre distance strictly beyond the summed radii
  function automatic bit apart_on_axis(input exact_t dx, dy, ex, ey, a1x, a1y, a2x, a2y,
                                       hf, hs, ax, ay);
    exact_t left, right, d1, d2, box_rad, obb_rad;
    left    = magnitude(dx * ax + dy * ay) * AXIS_ONE;
    box_rad = ex * magnitude(ax) + ey * magnitude(ay);
    d1      = a1x * ax + a1y * ay;
    d2      = a2x * ax + a2y * ay;
    obb_rad = 2 * (hf * magnitude(d1) + hs * magnitude(d2));
    right   = box_rad * AXIS_ONE + obb_rad;
    return left > right;
  endfunction

  // overlap unless world x, world y or either box axis separates
  function automatic bit predict_overlap(box_pair_t p);
    exact_t dx, dy, ex, ey, a1x, a1y, a2x, a2y, hf, hs, one, zero;
    dx   = 2 * exact_t'(signed'(p.obb_center_x)) - signed'(p.box_min_x) - signed'(p.box_max_x);
    dy   = 2 * exact_t'(signed'(p.obb_center_y)) - signed'(p.box_min_y) - signed'(p.box_max_y);
    ex   = exact_t'(signed'(p.box_max_x)) - signed'(p.box_min_x);
    ey   = exact_t'(signed'(p.box_max_y)) - signed'(p.box_min_y);
    a1x  = exact_t'(signed'(p.first_axis_x));
    a1y  = exact_t'(signed'(p.first_axis_y));
    a2x  = exact_t'(signed'(p.second_axis_x));
    a2y  = exact_t'(signed'(p.second_axis_y));
    hf   = exact_t'(p.obb_half_first);
    hs   = exact_t'(p.obb_half_second);
    one  = exact_t'(AXIS_ONE);
    zero = '0;
    return !(apart_on_axis(dx, dy, ex, ey, a1x, a1y, a2x, a2y, hf, hs, one, zero) ||
             apart_on_axis(dx, dy, ex, ey, a1x, a1y, a2x, a2y, hf, hs, zero, one) ||
             apart_on_axis(dx, dy, ex, ey, a1x, a1y, a2x, a2y, hf, hs, a1x, a1y) ||
             apart_on_axis(dx, dy, ex, ey, a1x, a1y, a2x, a2y, hf, hs, a2x, a2y));
  endfunction

  function automatic stim_row_t mk_row(input longint cx, cy, a1x, a1y, a2x, a2y, hf, hs,
                                       mnx, mny, mxx, mxy, input want_t want);
    stim_row_t r;
    r.pair.obb_center_x    = coord_t'(cx);
    r.pair.obb_center_y    = coord_t'(cy);
    r.pair.first_axis_x    = axis_t'(a1x);
    r.pair.first_axis_y    = axis_t'(a1y);
    r.pair.second_axis_x   = axis_t'(a2x);
    r.pair.second_axis_y   = axis_t'(a2y);
    r.pair.obb_half_first  = half_t'(hf);
    r.pair.obb_half_second = half_t'(hs);
    r.pair.box_min_x       = coord_t'(mnx);
    r.pair.box_min_y       = coord_t'(mny);
    r.pair.box_max_x       = coord_t'(mxx);
    r.pair.box_max_y       = coord_t'(mxy);
    r.want                 = want;
    return r;
  endfunction

  // directed table: unit boxes, touching, extremes and degenerate shapes
  function automatic stim_row_t directed_row(int row);
    localparam longint Q = COORD_ONE;
    localparam longint A = AXIS_ONE;
    case (row)
      // centred unit box inside a unit aligned box
      0:  return mk_row(0, 0, A, 0, 0, A, Q, Q, -Q, -Q, Q, Q, WANT_OVERLAP);
      // touching on world x, then one step past it
      1:  return mk_row(2*Q, 0, A, 0, 0, A, Q, Q, -Q, -Q, Q, Q, WANT_OVERLAP);
      2:  return mk_row(2*Q+1, 0, A, 0, 0, A, Q, Q, -Q, -Q, Q, Q, WANT_APART);
      // touching on world y from below, then one step past it
      3:  return mk_row(0, -2*Q, A, 0, 0, A, Q, Q, -Q, -Q, Q, Q, WANT_OVERLAP);
      4:  return mk_row(0, -2*Q-1, A, 0, 0, A, Q, Q, -Q, -Q, Q, Q, WANT_APART);
      // zero axes: the oriented box shrinks to its centre
      5:  return mk_row(0, 0, 0, 0, 0, 0, 0, 0, -Q, -Q, Q, Q, WANT_OVERLAP);
      6:  return mk_row(5*Q, 0, 0, 0, 0, 0, HMAX, HMAX, -Q, -Q, Q, Q, WANT_APART);
      // min above max gives a negative extent
      7:  return mk_row(0, 0, 0, 0, 0, 0, 0, 0, Q, Q, -Q, -Q, WANT_APART);
      8:  return mk_row(0, 0, A, 0, 0, A, 3*Q, 3*Q, Q, Q, -Q, -Q, WANT_PREDICTED);
      // point against point at the same spot
      9:  return mk_row(Q, Q, A, 0, 0, A, 0, 0, Q, Q, Q, Q, WANT_OVERLAP);
      // 45 degree box near the corner, apart on a box axis only, then closer
      10: return mk_row(144179, 144179, DIAG, DIAG, -DIAG, DIAG, Q, Q, -Q, -Q, Q, Q,
                        WANT_PREDICTED);
      11: return mk_row(104858, 104858, DIAG, DIAG, -DIAG, DIAG, Q, Q, -Q, -Q, Q, Q,
                        WANT_PREDICTED);
      // unnormalised and skewed axes
      12: return mk_row(Q, 0, 2*A, A, A, 3*A/2, Q/2, Q/4, -Q, -Q, 0, 0, WANT_PREDICTED);
      // field extremes
      13: return mk_row(CMAX, CMAX, AMAX, AMAX, AMAX, AMAX, HMAX, HMAX, CMAX, CMAX, CMAX, CMAX,
                        WANT_PREDICTED);
      14: return mk_row(CMIN, CMIN, AMIN, AMIN, AMIN, AMIN, 0, 0, CMIN, CMIN, CMIN, CMIN,
                        WANT_PREDICTED);
      15: return mk_row(CMIN, CMAX, AMIN, AMAX, AMAX, AMIN, HMAX, HMAX, CMIN, CMIN, CMAX, CMAX,
                        WANT_PREDICTED);
      16: return mk_row(CMAX, CMIN, AMIN, AMIN, AMIN, AMIN, HMAX, 0, CMAX, CMAX, CMIN, CMIN,
                        WANT_PREDICTED);
      default: return mk_row(CMIN, CMAX, AMAX, AMIN, AMIN, AMAX, 0, HMAX, CMAX, CMIN, CMIN,
                             CMAX, WANT_PREDICTED);
    endcase
  endfunction

  function automatic box_pair_t raw_pair();
    box_pair_t p;
    p.obb_center_x    = coord_t'($urandom);
    p.obb_center_y    = coord_t'($urandom);
    p.first_axis_x    = axis_t'($urandom);
    p.first_axis_y    = axis_t'($urandom);
    p.second_axis_x   = axis_t'($urandom);
    p.second_axis_y   = axis_t'($urandom);
    p.obb_half_first  = half_t'($urandom);
    p.obb_half_second = half_t'($urandom);
    p.box_min_x       = coord_t'($urandom);
    p.box_min_y       = coord_t'($urandom);
    p.box_max_x       = coord_t'($urandom);
    p.box_max_y       = coord_t'($urandom);
    return p;
  endfunction

  // mostly rotated boxes near an ordered aligned box, some raw noise and broken shapes
  function automatic box_pair_t random_pair();
    box_pair_t   p;
    stim_row_t   row;
    coord_t      swap_tmp;
    int unsigned pick;
    int unsigned k;
    int unsigned span_u;
    longint      span, bx, by, cx, cy, a1x, a1y, len;
    real         ang;
    pick = $urandom_range(0, 99);
    if (pick < 15) return raw_pair();
    k      = $urandom_range(2, 27);
    span   = longint'(1) << k;
    span_u = 32'd1 << k;
    bx     = longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29);
    by     = longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29);
    cx     = bx + longint'($urandom_range(0, 4 * span_u)) - 2 * span;
    cy     = by + longint'($urandom_range(0, 4 * span_u)) - 2 * span;
    len    = ($urandom_range(0, 3) == 0) ?
             longint'($urandom_range(32'(AXIS_ONE / 2), 32'(2 * AXIS_ONE - 1))) : AXIS_ONE;
    ang    = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
    a1x    = longint'($rtoi(len * $cos(ang)));
    a1y    = longint'($rtoi(len * $sin(ang)));
    row    = mk_row(cx, cy, a1x, a1y, -a1y, a1x,
                    longint'($urandom_range(0, span_u)), longint'($urandom_range(0, span_u)),
                    bx - longint'($urandom_range(0, span_u)),
                    by - longint'($urandom_range(0, span_u)),
                    bx + longint'($urandom_range(0, span_u)),
                    by + longint'($urandom_range(0, span_u)), WANT_PREDICTED);
    p      = row.pair;
    if (pick >= 80) begin
      case ($urandom_range(0, 4))
        0: begin
          swap_tmp = p.box_min_x;
          p.box_min_x = p.box_max_x;
          p.box_max_x = swap_tmp;
        end
        1: begin
          swap_tmp = p.box_min_y;
          p.box_min_y = p.box_max_y;
          p.box_max_y = swap_tmp;
        end
        2: begin
          p.first_axis_x  = axis_t'($urandom);
          p.first_axis_y  = axis_t'($urandom);
          p.second_axis_x = axis_t'($urandom);
          p.second_axis_y = axis_t'($urandom);
        end
        3: begin
          if ($urandom_range(0, 1)) begin
            p.first_axis_x = '0;
            p.first_axis_y = '0;
          end else begin
            p.second_axis_x = '0;
            p.second_axis_y = '0;
          end
        end
        default: begin
          p.obb_half_first  = '1;
          p.obb_half_second = $urandom_range(0, 1) ? '1 : '0;
          p.obb_center_x    = $urandom_range(0, 1) ? coord_t'(CMAX) : coord_t'(CMIN);
        end
      endcase
    end
    return p;
  endfunction

  // mostly short gaps, a few long ones, and stretches at full rate
  function automatic int pick_gap(int item);
    int unsigned r;
    if (item % 300 < 60) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // present one pair after a gap and hold it until the transfer
  task automatic send_pair(input box_pair_t p, input want_t want, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= raw_pair();
    end
    @(negedge clk);
    start    <= 1'b1;
    cmd      <= p;
    cmd_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // transfer capture, result check and watchdog
  always @(posedge clk) begin
    if (start && !busy) begin
      due = (cmd_want == WANT_PREDICTED) ? predict_overlap(cmd) : (cmd_want == WANT_OVERLAP);
      overlap_due.push_back(due);
      pairs_sent++;
    end
    if (rst_n && out_strobe) begin
      if (overlap_due.size() == 0) begin
        note_failure($sformatf("result %0b with none outstanding", out_overlap));
      end else begin
        due = overlap_due.pop_front();
        if (out_overlap !== due)
          note_failure($sformatf("overlap expected %0b actual %0b", due, out_overlap));
      end
      if (out_overlap === 1'b1) seen_overlap++;
      else seen_apart++;
    end
    if ((start && !busy) || (rst_n && out_strobe)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // reset, directed table, random pairs, drain
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      stim_row_t r;
      r = directed_row(row);
      send_pair(r.pair, r.want, (row % 4 == 3) ? pick_gap(row + 100) : 0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) send_pair(random_pair(), WANT_PREDICTED, pick_gap(i));
    @(negedge clk);
    start <= 1'b0;
    while (overlap_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (overlap_due.size() != 0) note_failure("results still outstanding at the end");
    $display("covered %0d box pairs (%0d directed): %0d overlapping, %0d apart, %0d failures",
             pairs_sent, DIRECTED_ROWS, seen_overlap, seen_apart, failures);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
